// ----- hdl/tml_pkg.sv -----
// Shared types and constants for the tabu move list match block.
// Used by tml_ctrl, tml_dpath and the top level tabu_move_list_match.
package tml_pkg;

  localparam int CITY_W  = 10;
  localparam int TUPLE_W = 4 * CITY_W;
  localparam int LEN_W   = 7;
  localparam int STAT_W  = 2;
  localparam int USER_W  = 2;
  localparam int OUT_W   = 8;

  // Bit positions inside the input tuser word.
  localparam int USER_REQ  = 0;
  localparam int USER_TIME = 1;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_NONE  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_MATCH = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_TIME  = 2'd2;

  localparam logic [LEN_W-1:0] LEN_RESET = 7'd64;

  typedef struct packed {
    logic capture;
    logic scan_clear;
    logic scan_run;
    logic wr_first;
    logic wr_second;
    logic load_out;
  } tml_cmd_t;

  typedef struct packed {
    logic scan_done;
  } tml_stat_t;

endpackage

// ----- hdl/tabu_move_list_match.sv -----
// Top level of the tabu move list match block.
// Instantiates tml_ctrl and tml_dpath; depends on tml_pkg.
//
// A ring of LIST_DEPTH four-city moves. A lookup transfer scans stored
// entries one per cycle through the single read port of the tuple memory,
// checking all four symmetric arrangements of the move against each entry.
// It reads up to min(effective length, entries written so far) entries,
// where the effective length is list_length with zero read as one and values
// above LIST_DEPTH read as LIST_DEPTH. A match ends the scan early, and a
// lookup with no entries written yet reads none.
// An insert makes two memory writes, and a transfer with time_up set
// skips the writes and the scan. One item is worked on at a time; the result
// sits in an output register, so a new item is taken while the last
// result waits. An item whose result is ready while the output register is
// still full waits in its final state until m_axis_tready frees it.
// list_length may only be written while the block is idle.
module tabu_move_list_match #(
  parameter int LIST_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [tml_pkg::LEN_W-1:0]    cfg_wdata,      // list_length
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // city_a [9:0], city_b [19:10], city_c [29:20], city_d [39:30]
  input  logic [tml_pkg::TUPLE_W-1:0]  s_axis_tdata,
  // req_type [0], time_up [1]
  input  logic [tml_pkg::USER_W-1:0]   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // status [1:0], zero fill [7:2]
  output logic [tml_pkg::OUT_W-1:0]    m_axis_tdata
);
  import tml_pkg::*;

  tml_cmd_t          cmd;
  tml_stat_t         stat;
  logic [STAT_W-1:0] status;

  tml_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_user   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tml_dpath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_tuple  (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .status    (status)
  );

  assign m_axis_tdata = {{(OUT_W - STAT_W){1'b0}}, status};

endmodule

// ----- hdl/tml_dpath.sv -----
// Datapath of the tabu move list: configuration register, tuple memory,
// ring write pointer, fill count, scan counter and result register.
// Depends on tml_pkg; driven by commands from tml_ctrl.
module tml_dpath #(
  parameter int LIST_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [tml_pkg::LEN_W-1:0]    cfg_wdata,
  input  logic [tml_pkg::TUPLE_W-1:0]  in_tuple,
  input  logic [tml_pkg::USER_W-1:0]   in_user,
  input  tml_pkg::tml_cmd_t            cmd,
  output tml_pkg::tml_stat_t           stat,
  output logic [tml_pkg::STAT_W-1:0]   status
);
  import tml_pkg::*;

  localparam int PTR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  logic [LEN_W-1:0]   list_length;
  logic [CNT_W-1:0]   eff_length;
  logic [CITY_W-1:0]  city_a, city_b, city_c, city_d;
  logic               req_type, time_up;
  logic [PTR_W-1:0]   write_pointer;
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   wp_inc;
  logic [CNT_W-1:0]   scan_limit;
  logic [CNT_W-1:0]   scan_idx;
  logic               rd_pend;
  logic               hit;
  logic               rd_en;
  logic               wr_en;
  logic [TUPLE_W-1:0] wr_data;
  logic [TUPLE_W-1:0] rd_data;
  logic               match;
  logic [TUPLE_W-1:0] mem [LIST_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      list_length <= LEN_RESET;
    end else if (cfg_wen) begin
      list_length <= cfg_wdata;
    end
  end

  // Zero acts as one entry, and anything above the depth is clamped.
  always_comb begin
    if (list_length == '0) begin
      eff_length = CNT_W'(1);
    end else if (32'(list_length) > 32'(LIST_DEPTH)) begin
      eff_length = CNT_W'(LIST_DEPTH);
    end else begin
      eff_length = CNT_W'(list_length);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      city_a   <= in_tuple[0*CITY_W +: CITY_W];
      city_b   <= in_tuple[1*CITY_W +: CITY_W];
      city_c   <= in_tuple[2*CITY_W +: CITY_W];
      city_d   <= in_tuple[3*CITY_W +: CITY_W];
      req_type <= in_user[USER_REQ];
      time_up  <= in_user[USER_TIME];
    end
  end

  // The pointer only steps by one or returns to zero, so the written
  // entries always form a prefix of the memory and a fill count stands in
  // for per-entry valid bits.
  assign wp_inc  = CNT_W'(write_pointer) + CNT_W'(1);
  assign wr_en   = cmd.wr_first | cmd.wr_second;
  assign wr_data = cmd.wr_first ? {city_d, city_b, city_c, city_a}
                                : {city_d, city_c, city_b, city_a};

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      fill          <= '0;
    end else if (wr_en) begin
      write_pointer <= (wp_inc < eff_length) ? wp_inc[PTR_W-1:0] : '0;
      if (wp_inc > fill) begin
        fill <= wp_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[write_pointer] <= wr_data;
    end
  end

  assign scan_limit = (fill < eff_length) ? fill : eff_length;
  assign rd_en      = cmd.scan_run && (scan_idx < scan_limit) && !hit;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[scan_idx[PTR_W-1:0]];
    end
  end

  // Arrangements abcd, cdab, badc and dcba, first city in the low bits.
  assign match = (rd_data == {city_d, city_c, city_b, city_a}) ||
                 (rd_data == {city_b, city_a, city_d, city_c}) ||
                 (rd_data == {city_c, city_d, city_a, city_b}) ||
                 (rd_data == {city_a, city_b, city_c, city_d});

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
      hit      <= 1'b0;
    end else if (cmd.scan_clear) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
      hit      <= 1'b0;
    end else if (cmd.scan_run) begin
      rd_pend <= rd_en;
      if (rd_en) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (rd_pend && match) begin
        hit <= 1'b1;
      end
    end
  end

  assign stat.scan_done = !rd_pend && (hit || (scan_idx >= scan_limit));

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (time_up) begin
        status <= STATUS_TIME;
      end else if (req_type == REQ_INSERT) begin
        status <= STATUS_NONE;
      end else begin
        status <= hit ? STATUS_MATCH : STATUS_NONE;
      end
    end
  end

endmodule

// ----- hdl/tml_ctrl.sv -----
// Controller of the tabu move list: sequences capture, the two inserts,
// the scan and the result handoff. Depends on tml_pkg.
module tml_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tml_pkg::USER_W-1:0]  in_user,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tml_pkg::tml_cmd_t           cmd,
  input  tml_pkg::tml_stat_t          stat
);
  import tml_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    INSERT_ONE,
    INSERT_TWO,
    SCAN,
    FINISH
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_free;

  assign in_ready = (state == IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.capture    = accept;
    cmd.scan_clear = accept;
    case (state)
      IDLE: begin
        if (accept) begin
          if (in_user[USER_TIME]) begin
            state_next = FINISH;
          end else if (in_user[USER_REQ] == REQ_INSERT) begin
            state_next = INSERT_ONE;
          end else begin
            state_next = SCAN;
          end
        end
      end
      INSERT_ONE: begin
        cmd.wr_first = 1'b1;
        state_next   = INSERT_TWO;
      end
      INSERT_TWO: begin
        cmd.wr_second = 1'b1;
        state_next    = FINISH;
      end
      SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          state_next = FINISH;
        end
      end
      FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
